/* rtl/hrsp_pkg.sv */
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types and constants for the hexagonal ring spiral position generator.
// ----------------------------------------------------------------------------
package hrsp_pkg;

	// Largest count accepted; larger requests saturate here.
	localparam int MAX_PLANES = 64;

	// sqrt(3) in Q14.
	localparam int SQRT3_Q14 = 28378;

	// Rounding bias and shift for the Q14 product.
	localparam int Q14_SHIFT = 14;
	localparam logic [33:0] Q14_HALF = 34'(1 << (Q14_SHIFT - 1));

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} ctrl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;   // latch count, restart the walk
		logic issue;  // emit the current walk position, advance
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic issue_last;   // current walk position is the final one
		logic pipe_active;  // items still in the multiply stages
	} dp_sts_t;

	// |b| * sqrt3 in Q14, |b| up to 7.
	function automatic logic [17:0] sqrt3_mult(input logic [2:0] mag);
		logic [17:0] r;
		case (mag)
			3'd0:    r = 18'd0;
			3'd1:    r = 18'(SQRT3_Q14);
			3'd2:    r = 18'(2 * SQRT3_Q14);
			3'd3:    r = 18'(3 * SQRT3_Q14);
			3'd4:    r = 18'(4 * SQRT3_Q14);
			3'd5:    r = 18'(5 * SQRT3_Q14);
			3'd6:    r = 18'(6 * SQRT3_Q14);
			default: r = 18'(7 * SQRT3_Q14);
		endcase
		return r;
	endfunction

endpackage

/* rtl/hex_ring_spiral_positions_core.sv */
// ----------------------------------------------------------------------------
// hex_ring_spiral_positions_core
// Emits N hexagonal-lattice positions in spiral order for one count item:
// centre first, then ring k with 6k points counter-clockwise from (2k, 0).
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  -----------------------------------------
//  command   start / busy           plane_count
//  config    cfg_valid / cfg_ready  spacing_radius (Q8.8)
//  result    result_valid strobe    x_lattice, y_lattice, x_pos, y_pos,
//                                   last_item
//
//  An item is taken when start is high and busy is low. Its N results
//  (N = count, 0 read as 1, capped at MAX_PLANES) come one per cycle; the
//  first reaches the ports through the walk state and the three pipeline
//  registers. busy falls at the edge that takes the last one, and the
//  next item can be taken at the following edge.
//  The walk issues one position a cycle; the three stage multiply pipeline
//  (lattice point, products, rounding) carries each position to the ports.
//  Results are a one-cycle strobe; the receiver cannot stall them.
//  Reset (arst_n low) idles the block and sets the radius to 1.0 (256).
//  The radius register only takes writes while the block is idle.
//
module hex_ring_spiral_positions_core
	import hrsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// command
	input  logic               start,
	output logic               busy,
	input  logic [6:0]         plane_count,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        spacing_radius,
	// results
	output logic               result_valid,
	output logic signed [4:0]  x_lattice,
	output logic signed [3:0]  y_lattice,
	output logic signed [20:0] x_pos,
	output logic signed [20:0] y_pos,
	output logic               last_item
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// radius writes are held off while a run is in flight
	assign cfg_ready = ~busy;

	hrsp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	hrsp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.plane_count  (plane_count),
		.radius_we    (cfg_valid & cfg_ready),
		.radius_wdata (spacing_radius),
		.result_valid (result_valid),
		.x_lattice    (x_lattice),
		.y_lattice    (y_lattice),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.last_item    (last_item)
	);

endmodule

/* rtl/hrsp_ctrl.sv */
// ----------------------------------------------------------------------------
// hrsp_ctrl
// Run controller: idle, walk the spiral, drain the multiply pipeline.
// ----------------------------------------------------------------------------
module hrsp_ctrl
	import hrsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (sts.issue_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_active) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load  = 1'b0;
		cmd.issue = 1'b0;
		busy      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_WALK: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/hrsp_dp.sv */
// ----------------------------------------------------------------------------
// hrsp_dp
// Datapath: spiral walk counters, lattice point, scaling pipeline.
// ----------------------------------------------------------------------------
module hrsp_dp
	import hrsp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic [6:0]         plane_count,
	input  logic               radius_we,
	input  logic [15:0]        radius_wdata,
	output logic               result_valid,
	output logic signed [4:0]  x_lattice,
	output logic signed [3:0]  y_lattice,
	output logic signed [20:0] x_pos,
	output logic signed [20:0] y_pos,
	output logic               last_item
);

	// configuration
	logic [15:0] radius_q;

	// walk state
	logic [2:0] ring_q;   // 0 = centre
	logic [2:0] side_q;   // side of the ring, 0..5
	logic [2:0] step_q;   // step along the side, 0..ring-1
	logic [6:0] count_q;  // positions issued in this run
	logic [6:0] limit_q;  // positions to issue

	logic [6:0]        limit_d;
	logic signed [4:0] k, j, a_w, b_w;
	logic              issue_last;

	// stage 1: lattice point
	logic              valid_s1, last_s1;
	logic signed [4:0] a_s1;
	logic signed [3:0] b_s1;

	// stage 2: products
	logic              valid_s2, last_s2, yneg_s2;
	logic signed [4:0] a_s2;
	logic signed [3:0] b_s2;
	logic signed [20:0] x_s2;
	logic [33:0]       yprod_s2;

	// stage 3: output registers
	logic              valid_s3, last_s3;
	logic signed [4:0] a_s3;
	logic signed [3:0] b_s3;
	logic signed [20:0] x_s3, y_s3;

	logic [2:0]         bmag;
	logic signed [21:0] xprod;
	logic [33:0]        yround;
	logic [20:0]        ymag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= 16'd256;
		end else if (radius_we) begin
			radius_q <= radius_wdata;
		end
	end

	// zero reads as one, saturate at the maximum
	always_comb begin
		if (plane_count == 7'd0) begin
			limit_d = 7'd1;
		end else if (plane_count > 7'(MAX_PLANES)) begin
			limit_d = 7'(MAX_PLANES);
		end else begin
			limit_d = plane_count;
		end
	end

	assign issue_last = ((count_q + 7'd1) == limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q  <= '0;
			side_q  <= '0;
			step_q  <= '0;
			count_q <= '0;
			limit_q <= 7'd1;
		end else if (cmd.load) begin
			ring_q  <= '0;
			side_q  <= '0;
			step_q  <= '0;
			count_q <= '0;
			limit_q <= limit_d;
		end else if (cmd.issue) begin
			count_q <= count_q + 7'd1;
			if (ring_q == 3'd0) begin
				ring_q <= 3'd1;
				side_q <= '0;
				step_q <= '0;
			end else if (step_q == ring_q - 3'd1) begin
				step_q <= '0;
				if (side_q == 3'd5) begin
					side_q <= '0;
					ring_q <= ring_q + 3'd1;
				end else begin
					side_q <= side_q + 3'd1;
				end
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// position on the ring, counter-clockwise from vertex (2k, 0)
	assign k = $signed({2'b00, ring_q});
	assign j = $signed({2'b00, step_q});

	always_comb begin
		if (ring_q == 3'd0) begin
			a_w = '0;
			b_w = '0;
		end else begin
			case (side_q)
				3'd0: begin
					a_w = (k <<< 1) - j;
					b_w = j;
				end
				3'd1: begin
					a_w = k - (j <<< 1);
					b_w = k;
				end
				3'd2: begin
					a_w = -k - j;
					b_w = k - j;
				end
				3'd3: begin
					a_w = j - (k <<< 1);
					b_w = -j;
				end
				3'd4: begin
					a_w = (j <<< 1) - k;
					b_w = -k;
				end
				default: begin
					a_w = k + j;
					b_w = j - k;
				end
			endcase
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign bmag  = b_s1[3] ? 3'(-b_s1) : b_s1[2:0];
	assign xprod = $signed({1'b0, radius_q}) * a_s1;

	assign yround = yprod_s2 + Q14_HALF;
	assign ymag   = 21'(yround >> Q14_SHIFT);

	always_ff @(posedge clk) begin
		a_s1    <= a_w;
		b_s1    <= b_w[3:0];
		last_s1 <= issue_last;

		a_s2     <= a_s1;
		b_s2     <= b_s1;
		last_s2  <= last_s1;
		yneg_s2  <= b_s1[3];
		x_s2     <= xprod[20:0];
		yprod_s2 <= 34'(radius_q * sqrt3_mult(bmag));

		a_s3    <= a_s2;
		b_s3    <= b_s2;
		last_s3 <= last_s2;
		x_s3    <= x_s2;
		y_s3    <= yneg_s2 ? -$signed(ymag) : $signed(ymag);
	end

	assign sts.issue_last  = issue_last;
	assign sts.pipe_active = valid_s1 | valid_s2;

	assign result_valid = valid_s3;
	assign x_lattice    = a_s3;
	assign y_lattice    = b_s3;
	assign x_pos        = x_s3;
	assign y_pos        = y_s3;
	assign last_item    = last_s3;

endmodule

/* rtl/hrsp_chk.sv */
// ----------------------------------------------------------------------------
// hrsp_chk
// Port-level checks for the spiral position generator.
// ----------------------------------------------------------------------------
module hrsp_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic result_valid,
	input logic last_item
);

	// results only come out during a run
	a_result_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result outside a run");

	// an accepted item holds the block and shows nothing in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !result_valid))
		else $error("accept did not start a run");

	// nothing follows the flagged result; the run is over
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_item) |=> (!result_valid && !busy))
		else $error("result or run after last item");

	// a run ends only right after its last result
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(result_valid && last_item))
		else $error("run ended without last item");

	// no radius write mid-run
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> !busy)
		else $error("radius write during a run");

endmodule

bind hex_ring_spiral_positions_core hrsp_chk u_hrsp_chk (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hex_ring_spiral_positions_core: drives count items
// and radius writes, predicts each spiral position, checks every strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import hrsp_pkg::*;

	// room for ~200 random items of up to MAX_PLANES positions each plus idle gaps
	localparam int CYCLE_LIMIT = 200000;
	// settle wait after the last result; busy drops at the edge that takes it
	localparam int SETTLE_CYCLES = 8;

	// sides of a ring, walked counter-clockwise from vertex (2k, 0)
	localparam int SIDE_UP_LEFT    = 0;
	localparam int SIDE_LEFT       = 1;
	localparam int SIDE_DOWN_LEFT  = 2;
	localparam int SIDE_DOWN_RIGHT = 3;
	localparam int SIDE_RIGHT      = 4;

	typedef struct packed {
		logic signed [4:0]  xl;
		logic signed [3:0]  yl;
		logic signed [20:0] xp;
		logic signed [20:0] yp;
		logic               last;
	} spiral_pos_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [6:0]         plane_count = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [15:0]        spacing_radius = '0;
	logic               result_valid;
	logic signed [4:0]  x_lattice;
	logic signed [3:0]  y_lattice;
	logic signed [20:0] x_pos;
	logic signed [20:0] y_pos;
	logic               last_item;

	// predictor state: radius register and the walk position
	logic [15:0] radius_shadow = 16'd256;
	int unsigned walk_ring;
	int unsigned walk_offset;
	int unsigned walk_emitted;

	spiral_pos_t pending_pos_q[$];
	int          err_count = 0;
	int          cycle_count = 0;
	bit          quiet_tail = 1'b0;  // no idling in the last part of the run

	hex_ring_spiral_positions_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.plane_count    (plane_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.spacing_radius (spacing_radius),
		.result_valid   (result_valid),
		.x_lattice      (x_lattice),
		.y_lattice      (y_lattice),
		.x_pos          (x_pos),
		.y_pos          (y_pos),
		.last_item      (last_item)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Lattice point of position idx on ring k.
	function automatic void ring_point(input int k, input int idx,
			output int a, output int b);
		int side;
		int j;
		side = idx / k;
		j    = idx % k;
		case (side)
			SIDE_UP_LEFT:    begin a = 2 * k - j;  b = j;      end
			SIDE_LEFT:       begin a = k - 2 * j;  b = k;      end
			SIDE_DOWN_LEFT:  begin a = -k - j;     b = k - j;  end
			SIDE_DOWN_RIGHT: begin a = -2 * k + j; b = -j;     end
			SIDE_RIGHT:      begin a = -k + 2 * j; b = -k;     end
			default:         begin a = k + j;      b = -k + j; end
		endcase
	endfunction

	// Queue every position that one count item produces.
	function automatic void predict_spiral(input logic [6:0] count);
		int unsigned n;
		int          a;
		int          b;
		longint      mag;
		longint      y_scaled;
		spiral_pos_t p;
		n = count;
		if (n == 0)
			n = 1;
		if (n > MAX_PLANES)
			n = MAX_PLANES;
		walk_ring    = 0;
		walk_offset  = 0;
		walk_emitted = 0;
		while (walk_emitted < n) begin
			a = 0;
			b = 0;
			if (walk_ring != 0)
				ring_point(walk_ring, walk_offset, a, b);
			// y = radius * |b| * sqrt3, rounded half away from zero
			mag = (b < 0) ? -b : b;
			y_scaled = (mag * longint'(radius_shadow) * longint'(SQRT3_Q14) + 8192) >>> 14;
			if (b < 0)
				y_scaled = -y_scaled;
			p.xl   = 5'(a);
			p.yl   = 4'(b);
			p.xp   = 21'(longint'(radius_shadow) * longint'(a));
			p.yp   = 21'(y_scaled);
			p.last = (walk_emitted + 1 == n);
			pending_pos_q.push_back(p);
			walk_emitted++;
			if (walk_ring == 0) begin
				walk_ring   = 1;
				walk_offset = 0;
			end else begin
				walk_offset++;
				if (walk_offset >= 6 * walk_ring) begin
					walk_offset = 0;
					walk_ring   = (walk_ring + 1) & 7;
				end
			end
		end
	endfunction

	// Results are one-cycle strobes; compare each against the oldest prediction.
	always @(posedge clk) begin
		spiral_pos_t e;
		if (arst_n && result_valid) begin
			if (pending_pos_q.size() == 0) begin
				$display("%0t: unexpected position x_lat=%0d y_lat=%0d", $time,
					x_lattice, y_lattice);
				err_count++;
			end else begin
				e = pending_pos_q.pop_front();
				if (x_lattice !== e.xl) begin
					$display("%0t: x_lattice exp %0d got %0d", $time, e.xl, x_lattice);
					err_count++;
				end
				if (y_lattice !== e.yl) begin
					$display("%0t: y_lattice exp %0d got %0d", $time, e.yl, y_lattice);
					err_count++;
				end
				if (x_pos !== e.xp) begin
					$display("%0t: x_pos exp %0d got %0d", $time, e.xp, x_pos);
					err_count++;
				end
				if (y_pos !== e.yp) begin
					$display("%0t: y_pos exp %0d got %0d", $time, e.yp, y_pos);
					err_count++;
				end
				if (last_item !== e.last) begin
					$display("%0t: last_item exp %0b got %0b", $time, e.last, last_item);
					err_count++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("hex_ring_spiral_positions_core regression: fail");
			$finish;
		end
	end

	// Send one count item. start stays high after the accept so that a
	// back-to-back item needs no extra edge; a gap lowers it first.
	task automatic send_count(input logic [6:0] count, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		plane_count <= count;
		do
			@(posedge clk);
		while (busy);
		predict_spiral(count);
	endtask

	// Random idle burst, mostly none; none at all in the tail.
	function automatic int pick_gap();
		if (quiet_tail || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(1, 19);
	endfunction

	// Hold off until every predicted position has come out, then let the
	// pipeline settle so the block is idle.
	task automatic drain_positions();
		start <= 1'b0;
		while (pending_pos_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Radius write; only called with the block idle.
	task automatic write_radius(input logic [15:0] r);
		cfg_valid      <= 1'b1;
		spacing_radius <= r;
		do
			@(posedge clk);
		while (!cfg_ready);
		radius_shadow = r;
		cfg_valid     <= 1'b0;
	endtask

	// Default radius after reset, centre only and first ring.
	task automatic test_reset_radius();
		send_count(7'd1, 0);
		send_count(7'd7, 0);
		drain_positions();
	endtask

	// Zero count, ring boundaries, partial rings, saturation above MAX_PLANES.
	task automatic test_count_extremes();
		logic [6:0] counts[10] = '{7'd0, 7'd2, 7'd8, 7'd19, 7'd20, 7'd61,
			7'd64, 7'd65, 7'd127, 7'd100};
		foreach (counts[i])
			send_count(counts[i], (i % 3 == 1) ? 3 : 0);
		drain_positions();
	endtask

	// Radius extremes and alternating bit patterns over a full spiral.
	task automatic test_radius_sweep();
		logic [15:0] radii[5] = '{16'd0, 16'hFFFF, 16'd1, 16'hAAAA, 16'h5555};
		foreach (radii[i]) begin
			write_radius(radii[i]);
			send_count(7'd64, 0);
			drain_positions();
		end
	endtask

	// Random counts, radius rewritten between phases, idle bursts on both sides.
	task automatic test_random_spirals();
		logic [6:0] c;
		for (int i = 0; i < 200; i++) begin
			if (i % 40 == 0) begin
				drain_positions();
				write_radius(($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
					: 16'($urandom));
			end
			if (i == 170)
				quiet_tail = 1'b1;
			// mostly in range; some saturating counts to exercise the top bit
			if ($urandom_range(0, 7) == 0)
				c = 7'($urandom_range(65, 127));
			else
				c = 7'($urandom_range(0, MAX_PLANES));
			send_count(c, pick_gap());
		end
		drain_positions();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_radius();
		test_count_extremes();
		test_radius_sweep();
		test_random_spirals();
		// back to the reset value before the end
		write_radius(16'd256);
		send_count(7'd64, 0);
		drain_positions();
		if (err_count == 0)
			$display("hex_ring_spiral_positions_core regression: pass");
		else
			$display("hex_ring_spiral_positions_core regression: fail");
		$finish;
	end

endmodule
